>>> sv/mrtu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_pkg
// Types, codes and the CRC-16 byte update shared by the RTU slave engine.
// ----------------------------------------------------------------------------
package mrtu_pkg;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
		logic       rx_error;
	} in_word_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       tx_last;
		logic       driver_enable;
	} out_word_t;

	typedef enum logic [5:0] {
		PH_SYNC = 6'b000001,
		PH_WAIT = 6'b000010,
		PH_RX   = 6'b000100,
		PH_PRE  = 6'b001000,
		PH_BODY = 6'b010000,
		PH_POST = 6'b100000
	} phase_t;

	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_READY = 2'd2;

	localparam logic [1:0] KIND_READ = 2'd0;
	localparam logic [1:0] KIND_EXC  = 2'd1;
	localparam logic [1:0] KIND_ECHO = 2'd2;

	localparam logic [1:0] REG_ADDR     = 2'd0;
	localparam logic [1:0] REG_SILENCE  = 2'd1;
	localparam logic [1:0] REG_PREAMBLE = 2'd2;
	localparam logic [1:0] REG_HOLDING  = 2'd3;

	localparam logic [7:0]  FN_READ_HOLD = 8'h03;
	localparam logic [7:0]  FN_DIAG      = 8'h08;
	localparam logic [7:0]  EXC_FLAG     = 8'h80;
	localparam logic [7:0]  EXC_CODE     = 8'h03;
	localparam logic [7:0]  MAX_COUNT    = 8'd127;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> sv/modbus_rtu_slave_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_slave_engine_core
// Modbus RTU slave framing: frame capture, check and reply generation.
// ----------------------------------------------------------------------------
// Each word (received byte, timer tick or transmitter-ready event) is taken
// into an input register and handled once the output register can take a
// result, producing one result word there; one word per cycle is sustained while
// the result side keeps taking words. The frame store is a RAM with one write
// port and one registered read port; its read address is the next transmit
// position, so the echo byte for a position is already read when it is sent.
// No clearing pass after reset.
module modbus_rtu_slave_engine_core #(
	parameter int FRAME_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mrtu_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mrtu_pkg::out_word_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import mrtu_pkg::*;

	localparam int AW  = $clog2(FRAME_DEPTH);
	localparam int LW  = $clog2(FRAME_DEPTH + 2);
	localparam int PW  = (LW > 9) ? LW : 9;
	localparam logic [PW-1:0] DEPTH_P = PW'(FRAME_DEPTH);
	localparam logic [PW-1:0] MIN_LEN = PW'(8);
	localparam logic [PW-1:0] EXC_LEN = PW'(5);

	// configuration
	logic [7:0]  addr_q, sil_q, pre_q;
	logic [15:0] hold_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 8'd1;
			sil_q  <= 8'd148;
			pre_q  <= 8'd116;
			hold_q <= 16'd4;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ADDR:     addr_q <= pwdata[7:0];
				REG_SILENCE:  sil_q  <= pwdata[7:0];
				REG_PREAMBLE: pre_q  <= pwdata[7:0];
				REG_HOLDING:  hold_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ADDR:     prdata = {24'd0, addr_q};
			REG_SILENCE:  prdata = {24'd0, sil_q};
			REG_PREAMBLE: prdata = {24'd0, pre_q};
			REG_HOLDING:  prdata = {16'd0, hold_q};
			default:      prdata = 32'd0;
		endcase
	end

	// handshake
	in_word_t  item_s1;
	logic      valid_s1;
	out_word_t res_q;
	logic      res_valid_q;
	logic      go;

	assign go        = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready  = !valid_s1 || go;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// engine state
	phase_t        phase_q, phase_d;
	logic [7:0]    tick_q, tick_d;
	logic [PW-1:0] flen_q, flen_d;
	logic [15:0]   rxcrc_q, rxcrc_d, txcrc_q, txcrc_d;
	logic [1:0]    kind_q, kind_d;
	logic [PW-1:0] pos_q, pos_d, rlen_q, rlen_d;
	logic [7:0]    b0_q, b1_q, b4_q, b5_q;
	logic          wr_en;
	logic [7:0]    rd_data;
	logic [7:0]    tick_inc, limit, bb;
	out_word_t     res_d;

	mrtu_frame_ram #(.DEPTH(FRAME_DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (flen_q[AW-1:0]),
		.wr_data (item_s1.rx_byte),
		.rd_addr (pos_d[AW-1:0]),
		.rd_data (rd_data)
	);

	assign tick_inc = (tick_q != 8'hFF) ? tick_q + 8'd1 : tick_q;
	assign limit    = (phase_q == PH_PRE || phase_q == PH_POST) ? pre_q : sil_q;

	always_comb begin
		if (kind_q == KIND_ECHO) begin
			bb = rd_data;
		end else if (pos_q + PW'(2) == rlen_q) begin
			bb = txcrc_q[7:0];
		end else if (pos_q + PW'(1) == rlen_q) begin
			bb = txcrc_q[15:8];
		end else if (pos_q == '0) begin
			bb = b0_q;
		end else if (kind_q == KIND_EXC) begin
			bb = (pos_q == PW'(1)) ? (b1_q | EXC_FLAG) : EXC_CODE;
		end else if (pos_q == PW'(1)) begin
			bb = FN_READ_HOLD;
		end else if (pos_q == PW'(2)) begin
			bb = {b5_q[6:0], 1'b0};
		end else begin
			bb = pos_q[0] ? hold_q[15:8] : hold_q[7:0];
		end
	end

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		flen_d  = flen_q;
		rxcrc_d = rxcrc_q;
		txcrc_d = txcrc_q;
		kind_d  = kind_q;
		pos_d   = pos_q;
		rlen_d  = rlen_q;
		wr_en   = 1'b0;
		res_d   = '0;
		if (go) begin
			unique case (item_s1.opcode)
				OP_BYTE: begin
					if (phase_q == PH_SYNC || phase_q == PH_WAIT || phase_q == PH_RX) begin
						if (phase_q == PH_SYNC || item_s1.rx_error) begin
							tick_d  = '0;
							phase_d = PH_SYNC;
						end else if (phase_q == PH_RX && tick_q >= sil_q) begin
							tick_d  = '0;
							phase_d = PH_SYNC;
							flen_d  = '0;
						end else begin
							wr_en   = flen_q < DEPTH_P;
							if (flen_q <= DEPTH_P) flen_d = flen_q + PW'(1);
							rxcrc_d = crc_feed(rxcrc_q, item_s1.rx_byte);
							tick_d  = '0;
							phase_d = PH_RX;
						end
					end
				end
				OP_TICK: begin
					if (phase_q == PH_SYNC || phase_q == PH_RX ||
					    phase_q == PH_PRE || phase_q == PH_POST) begin
						tick_d = tick_inc;
						if (tick_inc >= limit) begin
							tick_d = '0;
							if (phase_q == PH_PRE) begin
								phase_d = PH_BODY;
								pos_d   = '0;
								txcrc_d = CRC_INIT;
							end else if (phase_q == PH_RX && flen_q >= MIN_LEN &&
							             flen_q <= DEPTH_P && b0_q == addr_q &&
							             rxcrc_q == 16'd0 &&
							             (b1_q == FN_READ_HOLD || b1_q == FN_DIAG)) begin
								phase_d = PH_PRE;
								pos_d   = '0;
								txcrc_d = CRC_INIT;
								if (b1_q == FN_DIAG) begin
									kind_d = KIND_ECHO;
									rlen_d = flen_q;
								end else if (b5_q > MAX_COUNT || b4_q != 8'd0) begin
									kind_d = KIND_EXC;
									rlen_d = EXC_LEN;
								end else begin
									kind_d = KIND_READ;
									rlen_d = {{(PW-9){1'b0}}, b5_q, 1'b0} + EXC_LEN;
								end
							end else begin
								phase_d = PH_WAIT;
								flen_d  = '0;
								rxcrc_d = CRC_INIT;
							end
						end
					end
				end
				OP_READY: begin
					if (phase_q == PH_BODY) begin
						if (pos_q < rlen_q) begin
							if (kind_q != KIND_ECHO && pos_q + PW'(2) < rlen_q)
								txcrc_d = crc_feed(txcrc_q, bb);
							res_d.tx_byte  = bb;
							res_d.tx_valid = 1'b1;
							res_d.tx_last  = pos_q + PW'(1) == rlen_q;
							pos_d          = pos_q + PW'(1);
						end else begin
							phase_d = PH_POST;
							tick_d  = '0;
						end
					end
				end
				default: ;
			endcase
			res_d.driver_enable = phase_d == PH_PRE || phase_d == PH_BODY || phase_d == PH_POST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SYNC;
			tick_q      <= '0;
			flen_q      <= '0;
			rxcrc_q     <= CRC_INIT;
			txcrc_q     <= CRC_INIT;
			kind_q      <= KIND_READ;
			pos_q       <= '0;
			rlen_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			flen_q  <= flen_d;
			rxcrc_q <= rxcrc_d;
			txcrc_q <= txcrc_d;
			kind_q  <= kind_d;
			pos_q   <= pos_d;
			rlen_q  <= rlen_d;
			if (go) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res_d;
		end
		if (wr_en) begin
			if (flen_q == PW'(0)) b0_q <= item_s1.rx_byte;
			if (flen_q == PW'(1)) b1_q <= item_s1.rx_byte;
			if (flen_q == PW'(4)) b4_q <= item_s1.rx_byte;
			if (flen_q == PW'(5)) b5_q <= item_s1.rx_byte;
		end
	end

	a_last_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tx_last |-> out_data.tx_valid)
		else $error("tx_last without tx_valid");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !out_ready |=> valid_s1 && res_valid_q)
		else $error("word lost under stall");

	a_body_kind: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> kind_q == KIND_READ || kind_q == KIND_EXC ||
		kind_q == KIND_ECHO)
		else $error("bad reply kind in body");

	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.tx_valid |-> out_data.tx_byte == 8'd0)
		else $error("stray tx_byte");

endmodule

>>> sv/mrtu_frame_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_frame_ram
// Frame byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mrtu_frame_ram #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [7:0]               rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the RTU slave engine: frames, ticks and ready events are fed in,
// every result word is compared with a local model of the slave.
// ----------------------------------------------------------------------------
module tb_top;
	import mrtu_pkg::*;

	localparam int DEPTH = 256;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	modbus_rtu_slave_engine_core #(.FRAME_DEPTH(DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// slave model state
	logic [7:0] m_addr, m_sil, m_pre;
	logic [15:0] m_hold;
	phase_t m_phase;
	logic [7:0] m_ticks;
	logic [7:0] m_store [DEPTH];
	int unsigned m_len, m_pos, m_rlen;
	logic [15:0] m_rxcrc, m_txcrc;
	logic [1:0] m_kind;

	out_word_t expected_words[$];
	int errors = 0;
	bit rx_stall_long = 0;

	function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
		c ^= {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction

	function automatic void slave_rearm();
		m_phase = PH_WAIT;
		m_len = 0;
		m_rxcrc = CRC_INIT;
		m_ticks = '0;
	endfunction

	function automatic void slave_reply(logic [1:0] kind, int unsigned len);
		m_kind = kind;
		m_rlen = len;
		m_pos = 0;
		m_txcrc = CRC_INIT;
		m_ticks = '0;
		m_phase = PH_PRE;
	endfunction

	function automatic void slave_end_frame();
		if (m_len < 8 || m_len > DEPTH || m_store[0] != m_addr || m_rxcrc != 0) begin
			slave_rearm();
		end else if (m_store[1] == FN_READ_HOLD) begin
			if (m_store[5] > MAX_COUNT || m_store[4] != 0) slave_reply(KIND_EXC, 5);
			else slave_reply(KIND_READ, m_store[5] * 2 + 5);
		end else if (m_store[1] == FN_DIAG) begin
			slave_reply(KIND_ECHO, m_len);
		end else begin
			slave_rearm();
		end
	endfunction

	function automatic logic [7:0] reply_byte(int unsigned p);
		if (m_kind == KIND_ECHO) return p < DEPTH ? m_store[p] : 8'h00;
		if (p + 2 == m_rlen) return m_txcrc[7:0];
		if (p + 1 == m_rlen) return m_txcrc[15:8];
		if (p == 0) return m_store[0];
		if (m_kind == KIND_EXC) return p == 1 ? (m_store[1] | EXC_FLAG) : EXC_CODE;
		if (p == 1) return FN_READ_HOLD;
		if (p == 2) return m_store[5] << 1;
		return ((p - 3) & 1) ? m_hold[7:0] : m_hold[15:8];
	endfunction

	function automatic out_word_t slave_step(in_word_t w);
		out_word_t r;
		logic [7:0] lim, b;
		r = '0;
		case (w.opcode)
			OP_BYTE: begin
				if (m_phase inside {PH_SYNC, PH_WAIT, PH_RX}) begin
					if (m_phase == PH_SYNC || w.rx_error) begin
						m_ticks = '0;
						m_phase = PH_SYNC;
					end else if (m_phase == PH_RX && m_ticks >= m_sil) begin
						m_ticks = '0;
						m_phase = PH_SYNC;
						m_len = 0;
					end else begin
						if (m_len < DEPTH) m_store[m_len] = w.rx_byte;
						if (m_len <= DEPTH) m_len++;
						m_rxcrc = crc_step(m_rxcrc, w.rx_byte);
						m_ticks = '0;
						m_phase = PH_RX;
					end
				end
			end
			OP_TICK: begin
				if (m_phase inside {PH_SYNC, PH_RX, PH_PRE, PH_POST}) begin
					lim = (m_phase inside {PH_PRE, PH_POST}) ? m_pre : m_sil;
					if (m_ticks < 255) m_ticks++;
					if (m_ticks >= lim) begin
						m_ticks = '0;
						if (m_phase == PH_SYNC || m_phase == PH_POST) slave_rearm();
						else if (m_phase == PH_RX) slave_end_frame();
						else begin
							m_phase = PH_BODY;
							m_pos = 0;
							m_txcrc = CRC_INIT;
						end
					end
				end
			end
			OP_READY: begin
				if (m_phase == PH_BODY) begin
					if (m_pos < m_rlen) begin
						b = reply_byte(m_pos);
						if (m_kind != KIND_ECHO && m_pos + 2 < m_rlen)
							m_txcrc = crc_step(m_txcrc, b);
						r.tx_byte = b;
						r.tx_valid = 1'b1;
						r.tx_last = (m_pos + 1 == m_rlen);
						m_pos++;
					end else begin
						m_phase = PH_POST;
						m_ticks = '0;
					end
				end
			end
			default: ;
		endcase
		r.driver_enable = m_phase inside {PH_PRE, PH_BODY, PH_POST};
		return r;
	endfunction

	task automatic send_word(in_word_t w);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) :
			(($urandom_range(0, 99) == 0) ? $urandom_range(10, 40) : 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		expected_words.push_back(slave_step(w));
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_checked(in_word_t w, out_word_t exp_word);
		out_word_t r;
		r = slave_step(w);
		if (r != exp_word) begin
			$error("table row: expected %h, model gives %h", exp_word, r);
			errors++;
		end
		expected_words.push_back(r);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain(int extra);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		logic [31:0] rd_exp;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ADDR: m_addr = val[7:0];
			REG_SILENCE: m_sil = val[7:0];
			REG_PREAMBLE: m_pre = val[7:0];
			default: m_hold = val[15:0];
		endcase
		rd_exp = (idx == REG_HOLDING) ? {16'd0, val[15:0]} : {24'd0, val[7:0]};
		@(posedge clk);
		if (prdata !== rd_exp) begin
			$error("prdata expected %h actual %h", rd_exp, prdata);
			errors++;
		end
	endtask

	function automatic in_word_t mk(logic [1:0] op, logic [7:0] b, logic e);
		in_word_t w;
		w.opcode = op;
		w.rx_byte = b;
		w.rx_error = e;
		return w;
	endfunction

	task automatic ticks(int n);
		for (int i = 0; i < n; i++) send_word(mk(OP_TICK, 8'($urandom), 1'($urandom)));
	endtask

	// silence, one frame with good or bad CRC, silence, then drain the reply
	task automatic run_frame(logic [7:0] bytes[$], bit good_crc, bit noise);
		logic [15:0] c;
		int n;
		c = CRC_INIT;
		foreach (bytes[i]) c = crc_step(c, bytes[i]);
		if (good_crc) begin
			bytes.push_back(c[7:0]);
			bytes.push_back(c[15:8]);
		end
		ticks(m_sil + 1);
		foreach (bytes[i]) begin
			send_word(mk(OP_BYTE, bytes[i], noise && $urandom_range(0, 30) == 0));
			if (noise && $urandom_range(0, 20) == 0) send_word(mk(OP_TICK, 8'h00, 1'b0));
		end
		ticks(m_sil);
		if (m_phase == PH_PRE) begin
			ticks(m_pre);
			n = 0;
			while (m_phase == PH_BODY && n < 400) begin
				if ($urandom_range(0, 15) == 0)
					send_word(mk(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom)));
				else send_word(mk(OP_READY, 8'($urandom), 1'($urandom)));
				n++;
			end
			ticks(m_pre);
		end
	endtask

	task automatic rand_frame();
		logic [7:0] q[$];
		int len, fn;
		q = {};
		fn = $urandom_range(0, 9);
		q.push_back($urandom_range(0, 5) == 0 ? 8'($urandom) : m_addr);
		q.push_back(fn < 5 ? FN_READ_HOLD : (fn < 8 ? FN_DIAG : 8'($urandom)));
		q.push_back(8'($urandom));
		q.push_back(8'($urandom));
		q.push_back($urandom_range(0, 4) == 0 ? 8'($urandom) : 8'h00);
		q.push_back($urandom_range(0, 6) == 0 ? 8'($urandom) : 8'($urandom_range(0, 6)));
		len = ($urandom_range(0, 20) == 0) ? $urandom_range(0, 12) : 0;
		for (int i = 0; i < len; i++) q.push_back(8'($urandom));
		run_frame(q, $urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0);
	endtask

	// result side: random stalls, compare in order
	initial begin
		out_word_t e;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word %h", out_data);
					errors++;
				end else begin
					e = expected_words.pop_front();
					if (out_data.tx_byte !== e.tx_byte) begin
						$error("tx_byte expected %h actual %h", e.tx_byte, out_data.tx_byte);
						errors++;
					end
					if (out_data.tx_valid !== e.tx_valid) begin
						$error("tx_valid expected %b actual %b", e.tx_valid, out_data.tx_valid);
						errors++;
					end
					if (out_data.tx_last !== e.tx_last) begin
						$error("tx_last expected %b actual %b", e.tx_last, out_data.tx_last);
						errors++;
					end
					if (out_data.driver_enable !== e.driver_enable) begin
						$error("driver_enable expected %b actual %b",
							e.driver_enable, out_data.driver_enable);
						errors++;
					end
				end
			end
			if (rx_stall_long) out_ready <= 1'b1;
			else if ($urandom_range(0, 99) == 0) out_ready <= 1'b0;
			else if ($urandom_range(0, 3) == 0) out_ready <= 1'($urandom_range(0, 1));
			else out_ready <= 1'b1;
		end
	end

	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

	typedef struct {
		in_word_t w;
		bit has_exp;
		out_word_t exp_word;
	} row_t;

	initial begin
		row_t tbl[$];
		logic [7:0] q[$];
		m_addr = 8'd1; m_sil = 8'd148; m_pre = 8'd116; m_hold = 16'd4;
		m_phase = PH_SYNC; m_ticks = '0; m_len = 0; m_pos = 0; m_rlen = 0;
		m_rxcrc = CRC_INIT; m_txcrc = CRC_INIT; m_kind = KIND_READ;
		foreach (m_store[i]) m_store[i] = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: idle outputs, bytes in sync, ready and opcode 3 ignored
		tbl = '{
			'{mk(OP_BYTE, 8'hFF, 1'b1), 1, '0},
			'{mk(OP_BYTE, 8'h00, 1'b0), 1, '0},
			'{mk(OP_READY, 8'hAA, 1'b0), 1, '0},
			'{mk(2'd3, 8'h55, 1'b1), 1, '0},
			'{mk(OP_TICK, 8'hFF, 1'b1), 1, '0},
			'{mk(OP_READY, 8'h00, 1'b1), 0, '0}
		};
		foreach (tbl[i]) begin
			if (tbl[i].has_exp) send_checked(tbl[i].w, tbl[i].exp_word);
			else send_word(tbl[i].w);
		end
		drain(4);

		// extreme settings: zero silence/preamble, max holding value, address 255
		write_reg(REG_SILENCE, 32'd0);
		write_reg(REG_PREAMBLE, 32'd0);
		write_reg(REG_HOLDING, 32'hFFFF);
		write_reg(REG_ADDR, 32'd255);
		q = '{8'hFF, FN_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h02};
		run_frame(q, 1, 0);
		q = '{8'hFF, FN_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'd128};
		run_frame(q, 1, 0);
		q = '{8'hFF, FN_READ_HOLD, 8'h00, 8'h00, 8'h01, 8'h01};
		run_frame(q, 1, 0);
		q = '{8'hFF, FN_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h00};
		run_frame(q, 1, 0);
		q = '{8'hFF, FN_DIAG, 8'h00, 8'h00, 8'h12, 8'h34};
		run_frame(q, 1, 0);
		drain(4);

		write_reg(REG_ADDR, 32'd0);
		write_reg(REG_SILENCE, 32'd3);
		write_reg(REG_PREAMBLE, 32'd2);
		write_reg(REG_HOLDING, 32'h0000);
		// overlong frame gets dropped
		q = {};
		for (int i = 0; i < DEPTH + 4; i++)
			q.push_back(i == 0 ? 8'h00 : (i == 1 ? FN_DIAG : 8'($urandom)));
		run_frame(q, 1, 0);
		q = '{8'h00, FN_READ_HOLD, 8'h00, 8'h00, 8'h00, MAX_COUNT};
		run_frame(q, 1, 0);
		drain(4);

		// random phases with a few settings, extremes included
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_ADDR, ph == 3 ? 32'd255 : $urandom_range(0, 255));
			write_reg(REG_SILENCE, ph == 2 ? 32'd255 : $urandom_range(1, 5));
			write_reg(REG_PREAMBLE, $urandom_range(1, 4));
			write_reg(REG_HOLDING, $urandom);
			for (int f = 0; f < (ph == 2 ? 1 : 3); f++) begin
				rand_frame();
				if ($urandom_range(0, 3) == 0) ticks($urandom_range(0, 6));
				if ($urandom_range(0, 5) == 0)
					send_word(mk(2'($urandom), 8'($urandom), 1'($urandom)));
			end
			rx_stall_long = 1;
			drain(4);
			rx_stall_long = 0;
		end

		drain(20);
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
